@@ hdl/tchp_pkg.sv @@
// Package for the trace-context header parser.
// Holds the layout constants, the queue entry type and the hex decode function.
// No dependencies.
package tchp_pkg;

  localparam int unsigned PosWidth   = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [PosWidth-1:0] HdrLen       = 6'd55;
  localparam logic [PosWidth-1:0] PosVerLast   = 6'd1;
  localparam logic [PosWidth-1:0] PosDashVer   = 6'd2;
  localparam logic [PosWidth-1:0] PosUpperLast = 6'd18;
  localparam logic [PosWidth-1:0] PosLowerLast = 6'd34;
  localparam logic [PosWidth-1:0] PosDashTrace = 6'd35;
  localparam logic [PosWidth-1:0] PosSpanLast  = 6'd51;
  localparam logic [PosWidth-1:0] PosDashSpan  = 6'd52;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] LowOffset = 8'h57;
  localparam logic [7:0] UpOffset  = 8'h37;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_UPPER,
    ACT_LOWER,
    ACT_SPAN,
    ACT_FLAGS
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [3:0] digit;
    logic       bad;
    logic       at_len;
    logic       last;
  } entry_t;

  // bit 4 set when the character is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero;
      return {1'b1, t[3:0]};
    end
    if (c >= CharLowA && c <= CharLowF) begin
      t = c - LowOffset;
      return {1'b1, t[3:0]};
    end
    if (c >= CharUpA && c <= CharUpF) begin
      t = c - UpOffset;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage

@@ hdl/tchp_if.sv @@
// Stream interfaces of the trace-context header parser.
// Input byte channel and result channel; no dependencies.
interface tchp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       end_of_header;

  modport source (output valid, output header_byte, output end_of_header, input ready);
  modport sink (input valid, input header_byte, input end_of_header, output ready);
endinterface

interface tchp_out_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [63:0] trace_id_high;
  logic [63:0] trace_id_low;
  logic [63:0] span_id;
  logic [7:0]  trace_flags;

  modport source (output valid, output header_valid, output trace_id_high,
                  output trace_id_low, output span_id, output trace_flags, input ready);
  modport sink (input valid, input header_valid, input trace_id_high,
                input trace_id_low, input span_id, input trace_flags, output ready);
endinterface

@@ hdl/tchp_front.sv @@
// Front end: accepts header bytes, tracks the byte position and classifies each byte.
// Depends on tchp_pkg and tchp_in_if.
module tchp_front import tchp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tchp_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic [PosWidth-1:0] pos_q, pos_d, pos_next;
  logic                in_range;
  logic [4:0]          hex;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign in_range   = pos_q < HdrLen;
  assign pos_next   = in_range ? pos_q + 6'd1 : pos_q;
  assign hex        = hex_decode(in_i.header_byte);

  always_comb begin
    entry_o.act    = ACT_NONE;
    entry_o.digit  = hex[3:0];
    entry_o.bad    = 1'b0;
    entry_o.at_len = (pos_next == HdrLen);
    entry_o.last   = in_i.end_of_header;
    if (in_range) begin
      if (pos_q <= PosVerLast) begin
        entry_o.bad = (in_i.header_byte != CharZero);
      end else if (pos_q == PosDashVer || pos_q == PosDashTrace || pos_q == PosDashSpan) begin
        entry_o.bad = (in_i.header_byte != CharDash);
      end else begin
        entry_o.bad = !hex[4];
        if (pos_q <= PosUpperLast) begin
          entry_o.act = ACT_UPPER;
        end else if (pos_q <= PosLowerLast) begin
          entry_o.act = ACT_LOWER;
        end else if (pos_q <= PosSpanLast) begin
          entry_o.act = ACT_SPAN;
        end else begin
          entry_o.act = ACT_FLAGS;
        end
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = in_i.end_of_header ? '0 : pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ hdl/tchp_queue.sv @@
// Short register queue between front and back end of the header parser.
// Depends on tchp_pkg for the entry type.
module tchp_queue import tchp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/tchp_back.sv @@
// Back end: shifts hex digits into the id registers and forms the result transaction.
// Depends on tchp_pkg and tchp_out_if.
module tchp_back import tchp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     entry_i,
  input  logic       empty_i,
  output logic       pop_o,
  tchp_out_if.source out_o
);

  logic [63:0] upper_q, upper_d, lower_q, lower_d, span_q, span_d;
  logic [7:0]  flags_q, flags_d;
  logic        err_q, err_d;
  logic [63:0] upper_n, lower_n, span_n;
  logic [7:0]  flags_n;
  logic        err_n, ok;

  logic        ovalid_q, ovalid_d;
  logic        ohv_q;
  logic [63:0] ohigh_q, olow_q, ospan_q;
  logic [7:0]  oflags_q;

  assign pop_o = !empty_i && (!entry_i.last || !ovalid_q || out_o.ready);

  always_comb begin
    upper_n = upper_q;
    lower_n = lower_q;
    span_n  = span_q;
    flags_n = flags_q;
    err_n   = err_q | entry_i.bad;
    case (entry_i.act)
      ACT_UPPER: upper_n = {upper_q[59:0], entry_i.digit};
      ACT_LOWER: lower_n = {lower_q[59:0], entry_i.digit};
      ACT_SPAN:  span_n  = {span_q[59:0], entry_i.digit};
      ACT_FLAGS: flags_n = {flags_q[3:0], entry_i.digit};
      default: ;
    endcase
    ok = entry_i.at_len && !err_n && ((upper_n | lower_n) != '0);
  end

  always_comb begin
    upper_d  = upper_q;
    lower_d  = lower_q;
    span_d   = span_q;
    flags_d  = flags_q;
    err_d    = err_q;
    ovalid_d = ovalid_q && !out_o.ready;
    if (pop_o) begin
      if (entry_i.last) begin
        upper_d  = '0;
        lower_d  = '0;
        span_d   = '0;
        flags_d  = '0;
        err_d    = 1'b0;
        ovalid_d = 1'b1;
      end else begin
        upper_d = upper_n;
        lower_d = lower_n;
        span_d  = span_n;
        flags_d = flags_n;
        err_d   = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      lower_q  <= '0;
      span_q   <= '0;
      flags_q  <= '0;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      upper_q  <= upper_d;
      lower_q  <= lower_d;
      span_q   <= span_d;
      flags_q  <= flags_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.last) begin
      ohv_q    <= ok;
      ohigh_q  <= ok ? upper_n : '0;
      olow_q   <= ok ? lower_n : '0;
      ospan_q  <= ok ? span_n : '0;
      oflags_q <= ok ? flags_n : '0;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.header_valid  = ohv_q;
  assign out_o.trace_id_high = ohigh_q;
  assign out_o.trace_id_low  = olow_q;
  assign out_o.span_id       = ospan_q;
  assign out_o.trace_flags   = oflags_q;

endmodule

@@ hdl/trace_context_header_parser_unit.sv @@
// Trace-context header parser, top level.
// Depends on tchp_pkg, tchp_if, tchp_front, tchp_queue and tchp_back.
//
// Usage:
//   in_i  carries one header character per transaction (header_byte) with
//         end_of_header set on the final character.
//   out_o carries one result transaction per header: header_valid, the trace
//         id as two 64-bit binary halves, the span id and the flags byte.
//         When header_valid is 0 the id and flags fields are zero.
//   Throughput is one byte per cycle while the queue has room. The front end
//   checks position and character class; the back end shifts digits. A result
//   is valid on out_o after its final byte passes the queue and output register.
//   Reset clears the byte position, the id registers, the queue and out_o.valid.
//   When out_o stalls, bytes of the next header keep flowing until a final
//   byte reaches the back end; the QueueDepth-entry queue then fills and
//   in_i.ready drops until the pending result is taken.
module trace_context_header_parser_unit import tchp_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tchp_in_if.sink    in_i,
  tchp_out_if.source out_o
);

  logic   push, full, pop, empty;
  entry_t push_data, pop_data;

  tchp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_data)
  );

  tchp_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  tchp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (pop_data),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ dv/tchp_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the trace-context header parser testbench.
// Mirrors the byte parser and queues the expected result transactions; uses tchp_pkg.
package tchp_tb_pkg;
  import tchp_pkg::*;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic        header_valid;
    logic [63:0] trace_hi;
    logic [63:0] trace_lo;
    logic [63:0] span;
    logic [7:0]  flags;
  } parse_result_t;

  class traceparent_scoreboard;
    logic [PosWidth-1:0] pos;
    logic [63:0]         trace_hi;
    logic [63:0]         trace_lo;
    logic [63:0]         span;
    logic [7:0]          flags;
    bit                  malformed;
    parse_result_t       expected_q[$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    function new();
      clear();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void clear();
      pos       = '0;
      trace_hi  = '0;
      trace_lo  = '0;
      span      = '0;
      flags     = '0;
      malformed = 1'b0;
    endfunction

    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= CharZero && c <= CharNine) v = 4'(c - CharZero);
      else if (c >= CharLowA && c <= CharLowF) v = 4'(c - CharLowA + 8'd10);
      else if (c >= CharUpA && c <= CharUpF) v = 4'(c - CharUpA + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void report(string what, parse_result_t exp_r, parse_result_t got_r);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: exp v=%0b hi=%h lo=%h span=%h flags=%h got v=%0b hi=%h lo=%h span=%h flags=%h",
                 $time, what, exp_r.header_valid, exp_r.trace_hi, exp_r.trace_lo, exp_r.span,
                 exp_r.flags, got_r.header_valid, got_r.trace_hi, got_r.trace_lo, got_r.span,
                 got_r.flags);
    endfunction

    // one accepted input transaction
    function void note_byte(logic [7:0] c, logic eoh);
      logic [3:0]    d;
      bit            is_hex;
      parse_result_t r;
      if (pos < HdrLen) begin
        is_hex = hex_nibble(c, d);
        if (pos <= PosVerLast) begin
          if (c != CharZero) malformed = 1'b1;
        end else if (pos == PosDashVer || pos == PosDashTrace || pos == PosDashSpan) begin
          if (c != CharDash) malformed = 1'b1;
        end else begin
          if (!is_hex) malformed = 1'b1;
          if (pos <= PosUpperLast) trace_hi = {trace_hi[59:0], d};
          else if (pos <= PosLowerLast) trace_lo = {trace_lo[59:0], d};
          else if (pos <= PosSpanLast) span = {span[59:0], d};
          else flags = {flags[3:0], d};
        end
        pos++;
      end
      if (eoh) begin
        r = '0;
        if (pos == HdrLen && !malformed && (trace_hi != '0 || trace_lo != '0))
          r = '{1'b1, trace_hi, trace_lo, span, flags};
        expected_q.push_back(r);
        clear();
      end
    endfunction

    // one accepted result transaction
    function void check_result(parse_result_t got_r);
      parse_result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got_r);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got_r.header_valid !== exp_r.header_valid || got_r.trace_hi !== exp_r.trace_hi ||
          got_r.trace_lo !== exp_r.trace_lo || got_r.span !== exp_r.span ||
          got_r.flags !== exp_r.flags)
        report("result mismatch", exp_r, got_r);
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for trace_context_header_parser_unit: drives headers, checks results.
// Depends on tchp_pkg, tchp_if, tchp_tb_pkg and the parser RTL.
module tb_top;
  import tchp_pkg::*;
  import tchp_tb_pkg::*;

  localparam int unsigned ByteTarget    = 1450;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned WatchdogLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  tchp_in_if  in_if();
  tchp_out_if out_if();

  trace_context_header_parser_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  traceparent_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned ready_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;

  always @(posedge clk_i) begin : monitor
    parse_result_t got_r;
    bit            moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_byte(in_if.header_byte, in_if.end_of_header);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got_r = '{out_if.header_valid, out_if.trace_id_high, out_if.trace_id_low,
                  out_if.span_id, out_if.trace_flags};
        sb.check_result(got_r);
        moved = 1'b1;
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("trace_context_header_parser_unit regression: fail");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    hold_served  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        out_if.ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
        hold_served++;
      end else begin
        out_if.ready <= ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  function automatic char_t hex_char(logic [3:0] v);
    if (v < 4'd10) return char_t'(CharZero + v);
    return char_t'(($urandom_range(1) ? CharUpA : CharLowA) + v - 8'd10);
  endfunction

  function automatic void fill_header(ref char_t hdr[$], input logic [63:0] hi, lo, span,
                                      input logic [7:0] fl);
    hdr.delete();
    hdr.push_back(CharZero);
    hdr.push_back(CharZero);
    hdr.push_back(CharDash);
    for (int i = 15; i >= 0; i--) hdr.push_back(hex_char(hi[4*i +: 4]));
    for (int i = 15; i >= 0; i--) hdr.push_back(hex_char(lo[4*i +: 4]));
    hdr.push_back(CharDash);
    for (int i = 15; i >= 0; i--) hdr.push_back(hex_char(span[4*i +: 4]));
    hdr.push_back(CharDash);
    hdr.push_back(hex_char(fl[7:4]));
    hdr.push_back(hex_char(fl[3:0]));
  endfunction

  function automatic char_t wrong_char();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h2f;
      2: return 8'h3a;
      3: return 8'h40;
      4: return 8'h47;
      5: return 8'h60;
      6: return 8'h67;
      default: return char_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_char(char_t c, logic eoh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.header_byte   <= c;
    in_if.end_of_header <= eoh;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_header(char_t hdr[$]);
    foreach (hdr[i]) send_char(hdr[i], i == hdr.size() - 1);
  endtask

  task automatic random_header();
    char_t       hdr[$];
    logic [63:0] hi;
    logic [63:0] lo;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    hi   = {$urandom(), $urandom()};
    lo   = {$urandom(), $urandom()};
    if (kind >= 80 && kind < 87) begin
      hi = '0;
      lo = '0;
    end
    fill_header(hdr, hi, lo, {$urandom(), $urandom()}, 8'($urandom_range(255)));
    if (kind < 55) begin
      if ($urandom_range(99) < 30)
        repeat ($urandom_range(8, 1)) hdr.push_back(char_t'($urandom_range(255)));
    end else if (kind < 70) begin
      hdr[$urandom_range(54)] = wrong_char();
    end else if (kind < 80) begin
      n = $urandom_range(54, 1);
      while (hdr.size() > n) void'(hdr.pop_back());
    end else if (kind >= 87) begin
      hdr.delete();
      repeat ($urandom_range(70, 1)) hdr.push_back(char_t'($urandom_range(255)));
    end
    send_header(hdr);
  endtask

  initial begin
    char_t hdr[$];
    sb                  = new();
    send_idle_pct       = 0;
    ready_stall_pct     = 0;
    hold_requests       = 0;
    bytes_sent          = 0;
    quiet_cycles        = 0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.header_byte   = '0;
    in_if.end_of_header = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, trailing bytes ignored
    fill_header(hdr, '1, '1, '1, 8'hff);
    hdr.push_back(8'hff);
    hdr.push_back(8'h00);
    hdr.push_back(8'h80);
    send_header(hdr);
    // smallest nonzero trace id, zero span id
    fill_header(hdr, '0, 64'd1, '0, 8'h00);
    send_header(hdr);
    // all-zero trace id
    fill_header(hdr, '0, '0, 64'h0123_4567_89ab_cdef, 8'h01);
    send_header(hdr);
    // zero byte inside the trace id
    fill_header(hdr, 64'h8000_0000_0000_0001, '1, '1, 8'h80);
    hdr[20] = 8'h00;
    send_header(hdr);
    // bad version, missing dash
    fill_header(hdr, '1, '0, '1, 8'h5a);
    hdr[1]  = 8'h31;
    hdr[35] = CharZero;
    send_header(hdr);
    // one-byte header
    send_char(CharZero, 1'b1);

    // block fills while results are held off
    hold_requests++;
    repeat (4) begin
      fill_header(hdr, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  {$urandom(), $urandom()}, 8'($urandom_range(255)));
      send_header(hdr);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 78; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 78; end
        default: begin send_idle_pct = 7; ready_stall_pct = 7; end
      endcase
      while (bytes_sent < ByteTarget * (ph + 1) / 4)
        random_header();
    end

    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("trace_context_header_parser_unit regression: pass");
    else
      $display("trace_context_header_parser_unit regression: fail");
    $finish;
  end

endmodule

@@ trace_context_header_parser_unit.f @@
hdl/tchp_pkg.sv
hdl/tchp_if.sv
hdl/tchp_front.sv
hdl/tchp_queue.sv
hdl/tchp_back.sv
hdl/trace_context_header_parser_unit.sv
dv/tchp_tb_pkg.sv
dv/tb_top.sv
